### design/shac_pkg.sv
// shared types, constants and round functions for the sha-256 compression engine
package shac_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] CMD_ABSORB = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_IV     = 2'd2;

	typedef enum logic [1:0] {
		OP_ABSORB,
		OP_LOAD,
		OP_IV
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} eng_state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] data_word;
		logic [2:0]  state_index;
	} req_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        last_word;
	} rsp_item_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] data_word;
		logic [2:0]  state_index;
	} queue_item_t;

	typedef struct packed {
		logic        valid;
		queue_item_t item;
	} queue_head_t;

	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] w;
		begin
			unique case (idx)
				3'd0: w = 32'h6a09e667;
				3'd1: w = 32'hbb67ae85;
				3'd2: w = 32'h3c6ef372;
				3'd3: w = 32'ha54ff53a;
				3'd4: w = 32'h510e527f;
				3'd5: w = 32'h9b05688c;
				3'd6: w = 32'h1f83d9ab;
				3'd7: w = 32'h5be0cd19;
				default: w = 32'h0;
			endcase
			return w;
		end
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		begin
			unique case (r)
				6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
				6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
				6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
				6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
				6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
				6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
				6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
				6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
				6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
				6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
				6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
				6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
				6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
				6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
				6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
				6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
				6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
				6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
				6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
				6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
				6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
				6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
				6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
				6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
				6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
				6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
				6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
				6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
				6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
				6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
				6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
				6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
				default: k = 32'h0;
			endcase
			return k;
		end
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

### design/shac_front.sv
// front end: accepts command items, drops unused codes, queues the rest for the engine
module shac_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  shac_pkg::req_item_t   req,
	output shac_pkg::queue_head_t head,
	input  logic                  pop
);

	shac_pkg::queue_item_t             mem_q [shac_pkg::QDEPTH];
	logic [shac_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [shac_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [shac_pkg::QCNT_W-1:0]       count_q;
	logic                              accept;
	logic                              push;
	logic                              pop_ok;
	shac_pkg::queue_item_t             entry;

	assign req_stall = (count_q == shac_pkg::QCNT_W'(shac_pkg::QDEPTH));
	assign accept    = req_valid && !req_stall;

	always_comb begin
		entry.data_word   = req.data_word;
		entry.state_index = req.state_index;
		entry.op          = shac_pkg::OP_ABSORB;
		push              = accept;
		unique case (req.command)
			shac_pkg::CMD_ABSORB: entry.op = shac_pkg::OP_ABSORB;
			shac_pkg::CMD_LOAD:   entry.op = shac_pkg::OP_LOAD;
			shac_pkg::CMD_IV:     entry.op = shac_pkg::OP_IV;
			default:              push     = 1'b0;
		endcase
	end

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign pop_ok     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + shac_pkg::QPTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + shac_pkg::QPTR_W'(1);
			end
			if (push && !pop_ok) begin
				count_q <= count_q + shac_pkg::QCNT_W'(1);
			end else if (!push && pop_ok) begin
				count_q <= count_q - shac_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

### design/shac_engine.sv
// back end: message window, one-round-per-cycle compression, chaining value and digest output
module shac_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  shac_pkg::queue_head_t head,
	output logic                  pop,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output shac_pkg::rsp_item_t   rsp
);

	shac_pkg::eng_state_t state_q, state_d;

	logic [31:0] cv_q [8];
	logic [31:0] v_q [8];
	logic [31:0] win_q [16];
	logic [3:0]  word_cnt_q;
	logic [5:0]  round_q;
	logic [2:0]  emit_cnt_q;
	logic        out_valid_q;
	shac_pkg::rsp_item_t out_q;

	logic        start;
	logic        emit_load;
	logic        absorb;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] w_next;

	assign absorb = pop && (head.item.op == shac_pkg::OP_ABSORB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		start     = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			shac_pkg::ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.item.op == shac_pkg::OP_ABSORB && word_cnt_q == 4'd15) begin
						start   = 1'b1;
						state_d = shac_pkg::ST_ROUND;
					end
				end
			end
			shac_pkg::ST_ROUND: begin
				if (round_q == 6'd63) begin
					state_d = shac_pkg::ST_ADD;
				end
			end
			shac_pkg::ST_ADD: begin
				state_d = shac_pkg::ST_EMIT;
			end
			shac_pkg::ST_EMIT: begin
				emit_load = !out_valid_q || !rsp_stall;
				if (emit_load && emit_cnt_q == 3'd7) begin
					state_d = shac_pkg::ST_IDLE;
				end
			end
			default: state_d = shac_pkg::ST_IDLE;
		endcase
	end

	// round datapath
	always_comb begin
		ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1     = v_q[7] + shac_pkg::big_sigma1(v_q[4]) + ch + shac_pkg::round_k(round_q)
		         + win_q[0];
		t2     = shac_pkg::big_sigma0(v_q[0]) + maj;
		w_next = shac_pkg::small_sigma1(win_q[14]) + win_q[9]
		         + shac_pkg::small_sigma0(win_q[1]) + win_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) begin
				cv_q[k] <= shac_pkg::iv_word(3'(k));
			end
			word_cnt_q  <= '0;
			round_q     <= '0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				unique case (head.item.op)
					shac_pkg::OP_ABSORB: word_cnt_q <= word_cnt_q + 4'd1;
					shac_pkg::OP_LOAD:   cv_q[head.item.state_index] <= head.item.data_word;
					shac_pkg::OP_IV: begin
						for (int k = 0; k < 8; k++) begin
							cv_q[k] <= shac_pkg::iv_word(3'(k));
						end
					end
					default: ;
				endcase
			end
			if (start) begin
				round_q <= '0;
			end else if (state_q == shac_pkg::ST_ROUND) begin
				round_q <= round_q + 6'd1;
			end
			if (state_q == shac_pkg::ST_ADD) begin
				for (int k = 0; k < 8; k++) begin
					cv_q[k] <= cv_q[k] + v_q[k];
				end
				emit_cnt_q <= '0;
			end else if (emit_load) begin
				emit_cnt_q <= emit_cnt_q + 3'd1;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (absorb) begin
			for (int k = 0; k < 15; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[15] <= head.item.data_word;
		end else if (state_q == shac_pkg::ST_ROUND) begin
			for (int k = 0; k < 15; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[15] <= w_next;
		end
		if (start) begin
			for (int k = 0; k < 8; k++) begin
				v_q[k] <= cv_q[k];
			end
		end else if (state_q == shac_pkg::ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (emit_load) begin
			out_q.digest_word  <= cv_q[emit_cnt_q];
			out_q.digest_index <= emit_cnt_q;
			out_q.last_word    <= (emit_cnt_q == 3'd7);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

### design/sha256_block_compression.sv
// top level of the sha-256 block compression engine
// Items enter a four-deep queue and are carried out in order by the engine, which takes an
// absorb, a chaining-word load or a reload of the initial value from the queue while idle;
// the absorb that completes a sixteen-word block starts a compression of 64 rounds (one round
// per cycle through the single round unit), then an add into the chaining value and the
// hand-out of the updated words H0 to H7, the last one flagged, each word as the output side
// takes it. Until it is full, the queue keeps accepting items while a block is compressed
// or its digest waits downstream.
// Padding and length encoding are up to software.
module sha256_block_compression (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  shac_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output shac_pkg::rsp_item_t rsp
);

	shac_pkg::queue_head_t head;
	logic                  pop;

	shac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.head      (head),
		.pop       (pop)
	);

	shac_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### test/sha256_block_compression_tb.sv
// testbench for the sha-256 block compression engine: random and directed items checked by a scoreboard
module sha256_block_compression_tb;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 100;
	localparam longint TIMEOUT = 20_000_000;

	localparam logic [0:7][31:0] IV_WORDS = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	class digest_scoreboard;
		logic [31:0]         chain[8];
		logic [31:0]         window[16];
		logic [3:0]          fill;
		shac_pkg::rsp_item_t digest_q[$];
		int                  mismatches;

		function new();
			for (int i = 0; i < 8; i++) chain[i] = IV_WORDS[i];
			for (int i = 0; i < 16; i++) window[i] = 32'h0;
			fill = 4'd0;
			mismatches = 0;
		endfunction

		function logic [31:0] ror32(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] v[8];
			logic [31:0] w, t1, t2, x15, x2, g0, g1;
			for (int i = 0; i < 8; i++) v[i] = chain[i];
			for (int r = 0; r < 64; r++) begin
				if (r < 16) begin
					w = window[r];
				end else begin
					x15 = window[(r - 15) % 16];
					x2 = window[(r - 2) % 16];
					g0 = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
					g1 = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
					w = window[r % 16] + g0 + window[(r - 7) % 16] + g1;
					window[r % 16] = w;
				end
				t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w;
				t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
		endfunction

		function void note_item(shac_pkg::req_item_t it);
			shac_pkg::rsp_item_t e;
			case (it.command)
				shac_pkg::CMD_LOAD: chain[it.state_index] = it.data_word;
				shac_pkg::CMD_IV: for (int i = 0; i < 8; i++) chain[i] = IV_WORDS[i];
				shac_pkg::CMD_ABSORB: begin
					window[fill] = it.data_word;
					fill = fill + 4'd1;
					if (fill == 4'd0) begin
						compress();
						for (int k = 0; k < 8; k++) begin
							e.digest_word = chain[k];
							e.digest_index = k[2:0];
							e.last_word = (k == 7);
							digest_q.push_back(e);
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_digest(shac_pkg::rsp_item_t got);
			shac_pkg::rsp_item_t want;
			if (digest_q.size() == 0) begin
				report($sformatf("unexpected result word %h index %0d", got.digest_word,
					got.digest_index));
			end else begin
				want = digest_q.pop_front();
				if (got.digest_word !== want.digest_word)
					report($sformatf("digest_word got %h want %h (index %0d)",
						got.digest_word, want.digest_word, want.digest_index));
				if (got.digest_index !== want.digest_index)
					report($sformatf("digest_index got %0d want %0d",
						got.digest_index, want.digest_index));
				if (got.last_word !== want.last_word)
					report($sformatf("last_word got %b want %b (index %0d)",
						got.last_word, want.last_word, want.digest_index));
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	shac_pkg::req_item_t req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	shac_pkg::rsp_item_t rsp;

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_request = 1'b0;

	digest_scoreboard sb = new();

	sha256_block_compression dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) sb.note_item(req);
		if (arst_n && rsp_valid && !rsp_stall) sb.check_digest(rsp);
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		#(TIMEOUT);
		$display("== FAIL ==");
		$finish;
	end

	function automatic shac_pkg::req_item_t make_item(logic [1:0] cmd, logic [31:0] data,
		logic [2:0] idx);
		shac_pkg::req_item_t it;
		it.command = cmd;
		it.data_word = data;
		it.state_index = idx;
		return it;
	endfunction

	function automatic shac_pkg::req_item_t random_item();
		shac_pkg::req_item_t it;
		int pick;
		pick = $urandom_range(99);
		if (pick < 84) it.command = shac_pkg::CMD_ABSORB;
		else if (pick < 92) it.command = shac_pkg::CMD_LOAD;
		else if (pick < 97) it.command = shac_pkg::CMD_IV;
		else it.command = CMD_UNUSED;
		case ($urandom_range(9))
			0: it.data_word = 32'h0;
			1: it.data_word = 32'hffffffff;
			default: it.data_word = $urandom;
		endcase
		it.state_index = 3'($urandom_range(7));
		return it;
	endfunction

	task automatic send_item(shac_pkg::req_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_drained();
		int n;
		req_valid <= 1'b0;
		n = 0;
		do begin
			@(posedge clk);
			n++;
		end while (sb.digest_q.size() != 0 && n < DRAIN_LIMIT);
		if (sb.digest_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.digest_q.size()));
	endtask

	task automatic run_phase(int idle, int stall, int count);
		shac_pkg::req_item_t it;
		int sent;
		send_idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < count) begin
			it = random_item();
			send_item(it);
			if (it.command != CMD_UNUSED) sent++;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// "abc" block after an iv reload, then a partial block mixed with loads, the unused command and an iv reload
		send_item(make_item(shac_pkg::CMD_IV, 32'hffffffff, 3'd7));
		send_item(make_item(shac_pkg::CMD_ABSORB, 32'h61626380, 3'd0));
		for (int i = 1; i < 15; i++) send_item(make_item(shac_pkg::CMD_ABSORB, 32'h0, 3'd7));
		send_item(make_item(shac_pkg::CMD_ABSORB, 32'h00000018, 3'd0));
		send_item(make_item(shac_pkg::CMD_ABSORB, 32'hffffffff, 3'd7));
		send_item(make_item(shac_pkg::CMD_LOAD, 32'hffffffff, 3'd0));
		send_item(make_item(shac_pkg::CMD_LOAD, 32'h0, 3'd7));
		send_item(make_item(CMD_UNUSED, 32'hffffffff, 3'd7));
		send_item(make_item(shac_pkg::CMD_IV, 32'h0, 3'd0));
		send_item(make_item(shac_pkg::CMD_ABSORB, 32'h0, 3'd0));
		wait_drained();

		// receiver holds off while the sender keeps offering items
		hold_request = 1'b1;
		run_phase(0, 0, 48);
		wait_drained();

		run_phase(0, 0, 90);
		wait_drained();
		run_phase(88, 0, 90);
		wait_drained();
		run_phase(0, 88, 90);
		run_phase(31, 31, 90);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
